// ===== hw/rtl/zaphod_pkg.sv =====
package zaphod_pkg;

  localparam int unsigned SeedWidth = 64;
  localparam int unsigned WordWidth = 32;

  localparam logic [31:0] PiW0   = 32'h43f6a888;
  localparam logic [31:0] PiW1   = 32'h5a308d31;
  localparam logic [31:0] PiW2   = 32'h3198a2e0;
  localparam logic [31:0] LenMul = 32'hC41A7AB1;
  localparam logic [31:0] ByteMask = 32'h000000FF;

  localparam logic [31:0] PrimeA0 = 32'h9fade23b;
  localparam logic [31:0] PrimeA1 = 32'haa6f908d;
  localparam logic [31:0] PrimeA2 = 32'hcdf6b72d;
  localparam logic [31:0] PrimeB0 = 32'hc95d22a9;
  localparam logic [31:0] PrimeB1 = 32'h8497242b;
  localparam logic [31:0] PrimeB2 = 32'h9c5cc4e9;

  localparam int unsigned MixRounds1 = 4;
  localparam int unsigned MixRounds2 = 5;

  typedef logic [31:0] word_t;

  typedef enum logic [3:0] {
    ST_EXP_INIT,
    ST_EXP_SCR_A,
    ST_EXP_MUL_A,
    ST_EXP_MIX1,
    ST_EXP_SCR_B,
    ST_EXP_MUL_B,
    ST_EXP_MIX2,
    ST_IDLE,
    ST_LEN_MUL,
    ST_ABSORB,
    ST_MIX,
    ST_FINAL,
    ST_FIN1,
    ST_FIN2,
    ST_OUT
  } state_t;

  // datapath operations driven by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_EXP_INIT,
    OP_SCR_PRE_A,
    OP_SCR_POST_A,
    OP_SCR_PRE_B,
    OP_SCR_POST_B,
    OP_KEY_MIX,
    OP_START,
    OP_LEN_APPLY,
    OP_ABSORB,
    OP_MIX,
    OP_FINAL,
    OP_FIN1,
    OP_FIN2
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic is_short;
    logic need_mix;
  } dp_stat_t;

  function automatic word_t rol(input word_t x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic word_t ror(input word_t x, input int unsigned r);
    return (x >> r) | (x << (32 - r));
  endfunction

  function automatic word_t scr_pre(input word_t v_in);
    word_t v;
    v = v_in;
    v = v ^ (v >> 9);
    v = v ^ (v << 21);
    v = v ^ (v >> 16);
    return v;
  endfunction

  function automatic word_t scr_post(input word_t v_in);
    word_t v;
    v = v_in;
    v = v ^ (v >> 17);
    v = v ^ (v << 15);
    v = v ^ (v >> 23);
    return v;
  endfunction

  function automatic logic [95:0] mix3(input word_t a0, input word_t a1, input word_t a2);
    word_t v0, v1, v2;
    v0 = a0;
    v1 = a1;
    v2 = a2;
    v0 = rol(v0, 16) - v2;
    v1 = ror(v1, 13) ^ v2;
    v2 = rol(v2, 17) + v1;
    v0 = ror(v0, 2) + v1;
    v1 = ror(v1, 17) - v0;
    v2 = ror(v2, 7) ^ v0;
    return {v2, v1, v0};
  endfunction

  // short final mix; stages 1 and 2 return {c, a}
  function automatic logic [63:0] short_fin1(input word_t a_in, input word_t c_in);
    word_t a, c;
    a = a_in;
    c = c_in;
    a = a - c;
    c = rol(c, 8) ^ a;
    a = ror(a, 16) + c;
    c = c + a;
    a = a + (a >> 9);
    return {c, a};
  endfunction

  function automatic logic [63:0] short_fin2(input word_t a_in, input word_t c_in);
    word_t a, c;
    a = a_in;
    c = c_in;
    a = a + c;
    c = c ^ a;
    c = c + (c << 4);
    a = a - c;
    c = ror(c, 8) ^ a;
    return {c, a};
  endfunction

  function automatic word_t short_fin3(input word_t a_in, input word_t c_in);
    word_t a, c;
    a = a_in;
    c = c_in;
    a = rol(a, 16) ^ c;
    c = rol(c, 10) + a;
    a = ror(a, 30) + c;
    c = ror(c, 12);
    return a ^ c;
  endfunction

  // common finalize; stages 1 and 2 return {c, b, a}
  function automatic logic [95:0] common_fin1(input word_t a_in, input word_t b_in,
                                              input word_t c_in);
    word_t a, b, c;
    a = a_in;
    b = b_in;
    c = c_in;
    c = c + a;
    b = b - c;
    b = rol(b, 6);
    c = c ^ b;
    c = rol(c, 28);
    b = b ^ c;
    a = a + b;
    b = rol(b, 24);
    return {c, b, a};
  endfunction

  function automatic logic [95:0] common_fin2(input word_t a_in, input word_t b_in,
                                              input word_t c_in);
    word_t a, b, c;
    a = a_in;
    b = b_in;
    c = c_in;
    c = c + b;
    c = rol(c, 18) + b;
    a = a ^ c;
    a = rol(a, 20);
    c = c + a;
    b = b ^ c;
    a = a + b;
    return {c, b, a};
  endfunction

  function automatic word_t common_fin3(input word_t a_in, input word_t b_in,
                                        input word_t c_in);
    word_t a, b, c;
    a = a_in;
    b = b_in;
    c = c_in;
    a = rol(a, 5);
    c = c + a;
    c = rol(c, 22);
    a = a - b;
    b = b - c;
    b = rol(b, 17);
    return a ^ b ^ c;
  endfunction

endpackage

// ===== hw/rtl/zaphod_ctrl.sv =====
module zaphod_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 seed_we,
  input  logic                 chunk_valid,
  output logic                 chunk_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  zaphod_pkg::dp_stat_t stat,
  output zaphod_pkg::dp_cmd_t  cmd,
  output logic                 busy
);
  import zaphod_pkg::*;

  state_t      state, state_next;
  logic [2:0]  round, round_next;
  logic        out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_EXP_INIT;
      round    <= '0;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      round    <= round_next;
      out_full <= out_full_next;
    end
  end

  assign out_valid = out_full;

  always_comb begin
    state_next    = state;
    round_next    = round;
    out_full_next = out_full && !out_ready;
    cmd.op        = OP_NONE;
    cmd.load_out  = 1'b0;
    chunk_ready   = 1'b0;
    busy          = 1'b1;
    unique case (state)
      ST_EXP_INIT: begin
        cmd.op     = OP_EXP_INIT;
        state_next = ST_EXP_SCR_A;
      end
      ST_EXP_SCR_A: begin
        cmd.op     = OP_SCR_PRE_A;
        state_next = ST_EXP_MUL_A;
      end
      ST_EXP_MUL_A: begin
        cmd.op     = OP_SCR_POST_A;
        round_next = '0;
        state_next = ST_EXP_MIX1;
      end
      ST_EXP_MIX1: begin
        cmd.op     = OP_KEY_MIX;
        round_next = round + 3'd1;
        if (round == 3'(MixRounds1 - 1)) state_next = ST_EXP_SCR_B;
      end
      ST_EXP_SCR_B: begin
        cmd.op     = OP_SCR_PRE_B;
        state_next = ST_EXP_MUL_B;
      end
      ST_EXP_MUL_B: begin
        cmd.op     = OP_SCR_POST_B;
        round_next = '0;
        state_next = ST_EXP_MIX2;
      end
      ST_EXP_MIX2: begin
        cmd.op     = OP_KEY_MIX;
        round_next = round + 3'd1;
        if (round == 3'(MixRounds2 - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (seed_we) begin
          state_next = ST_EXP_INIT;
        end else begin
          chunk_ready = 1'b1;
          if (chunk_valid) begin
            if (stat.first) begin
              cmd.op     = OP_START;
              state_next = ST_LEN_MUL;
            end else begin
              cmd.op     = OP_ABSORB;
              state_next = ST_ABSORB;
            end
          end
        end
      end
      ST_LEN_MUL: begin
        cmd.op     = OP_LEN_APPLY;
        state_next = ST_ABSORB;
      end
      ST_ABSORB: begin
        // chunk already latched; decide the path
        if (stat.need_mix) begin
          cmd.op     = OP_MIX;
          state_next = stat.last ? ST_FINAL : ST_IDLE;
        end else begin
          state_next = stat.last ? ST_FINAL : ST_IDLE;
        end
      end
      ST_FINAL: begin
        cmd.op     = OP_FINAL;
        state_next = ST_FIN1;
      end
      ST_FIN1: begin
        cmd.op     = OP_FIN1;
        state_next = ST_FIN2;
      end
      ST_FIN2: begin
        cmd.op     = OP_FIN2;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_full || out_ready) begin
          cmd.load_out  = 1'b1;
          out_full_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_EXP_INIT;
    endcase
  end

endmodule

// ===== hw/rtl/zaphod_dp.sv =====
module zaphod_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  zaphod_pkg::dp_cmd_t  cmd,
  output zaphod_pkg::dp_stat_t stat,
  input  logic [63:0]          seed,
  input  logic [63:0]          chunk_data,
  input  logic                 first_chunk,
  input  logic                 last_chunk,
  input  logic [31:0]          message_length,
  output logic [31:0]          hash_value
);
  import zaphod_pkg::*;

  word_t       key0, key1, key2;
  word_t       v0, v1, v2;
  word_t       msg_len;
  logic [31:0] bytes_taken;
  logic [63:0] short_buffer;
  logic [63:0] chunk;
  logic        chunk_last;
  logic        chunk_pending;
  word_t       len_prod;
  word_t       fin_a, fin_b, fin_c;
  logic        fin_short;
  word_t       hash_reg;

  logic        is_short;
  logic [95:0] kmix;
  word_t       t0, t1;
  word_t       k0n, k1n, k2n;
  logic [2:0]  tail;
  logic [63:0] rest, lo;
  word_t       hi, sa, sb, sc, la, lb, lc;

  assign is_short       = (msg_len <= 32'd12);
  assign stat.first     = first_chunk;
  assign stat.last      = chunk_last;
  assign stat.is_short  = is_short;
  assign stat.need_mix  = !is_short && (!chunk_last || msg_len[2:0] == 3'd0);
  assign hash_value     = hash_reg;

  assign kmix = mix3(key0, key1, key2);
  assign t0   = seed[31:0] ^ PiW0;
  assign t1   = seed[63:32] ^ PiW1;

  // short path operands
  always_comb begin
    if (bytes_taken == '0) begin
      lo = chunk;
      hi = '0;
    end else begin
      lo = short_buffer;
      hi = chunk[31:0];
    end
    sa = v0;
    sb = v1;
    sc = v2;
    priority if (msg_len >= 32'd10 && msg_len <= 32'd12) begin
      if (msg_len == 32'd12) sc = sc + {hi[31:24], 24'd0};
      if (msg_len >= 32'd11) sc = sc + {8'd0, hi[23:16], 16'd0};
      sc = sc + {16'd0, hi[15:0]};
      sb = sb - lo[63:32];
      sa = sa + lo[31:0];
    end else if (msg_len == 32'd9 || msg_len == 32'd8) begin
      if (msg_len == 32'd9) sc = sc + {24'd0, hi[7:0]};
      sb = sb - lo[63:32];
      sa = sa + lo[31:0];
    end else if (msg_len == 32'd7 || msg_len == 32'd6) begin
      if (msg_len == 32'd7) sc = sc + {24'd0, lo[55:48]};
      sa = sa + {16'd0, lo[47:32]};
      sb = sb - lo[31:0];
    end else if (msg_len == 32'd5 || msg_len == 32'd4) begin
      if (msg_len == 32'd5) sa = sa + {24'd0, lo[39:32]};
      sb = sb - lo[31:0];
    end else if (msg_len == 32'd3 || msg_len == 32'd2) begin
      if (msg_len == 32'd3) sc = sc + {24'd0, lo[23:16]};
      sa = sa + {16'd0, lo[15:0]};
    end else if (msg_len == 32'd1) begin
      sa = sa + {24'd0, lo[7:0]};
    end else begin
      sc = sc ^ ByteMask;
    end
  end

  // long tail fold; mix of a full final chunk happens before this
  always_comb begin
    tail = msg_len[2:0];
    la   = v0;
    lb   = v1;
    lc   = v2;
    rest = chunk;
    if (tail >= 3'd4) begin
      lb   = lb - chunk[31:0];
      rest = {32'd0, chunk[63:32]};
    end
    la = la + {msg_len[7:0], 24'd0};
    unique case (tail[1:0])
      2'd3: begin
        lc = lc + {24'd0, rest[23:16]};
        la = la + {16'd0, rest[15:0]};
      end
      2'd2: la = la + {16'd0, rest[15:0]};
      2'd1: la = la + {24'd0, rest[7:0]};
      default: lc = lc ^ ByteMask;
    endcase
  end

  always_comb begin
    k0n = key0;
    k1n = key1;
    k2n = key2;
    unique case (cmd.op)
      OP_SCR_PRE_A, OP_SCR_PRE_B: begin
        k0n = scr_pre(key0);
        k1n = scr_pre(key1);
        k2n = scr_pre(key2);
      end
      OP_SCR_POST_A: begin
        k0n = scr_post(key0 * PrimeA0);
        k1n = scr_post(key1 * PrimeA1);
        k2n = scr_post(key2 * PrimeA2);
      end
      OP_SCR_POST_B: begin
        k0n = scr_post(key0 * PrimeB0);
        k1n = scr_post(key1 * PrimeB1);
        k2n = scr_post(key2 * PrimeB2);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0          <= '0;
      v1          <= '0;
      v2          <= '0;
      msg_len     <= '0;
      bytes_taken <= '0;
    end else begin
      unique case (cmd.op)
        OP_START: begin
          msg_len     <= message_length;
          v0          <= key0;
          v1          <= key1;
          v2          <= key2;
          bytes_taken <= '0;
        end
        OP_LEN_APPLY: v2 <= v2 ^ len_prod;
        OP_MIX: begin
          {v2, v1, v0} <= mix3(v0 + chunk[63:32], v1 - chunk[31:0], v2);
        end
        OP_FINAL: begin
          bytes_taken <= bytes_taken + 32'd8;
          // the long tail fold stays in the running words
          if (!is_short) begin
            v0 <= la;
            v1 <= lb;
            v2 <= lc;
          end
        end
        default: ;
      endcase
      // non-last chunks count here; last chunks count at finalize
      if (chunk_pending && !chunk_last) begin
        if (!is_short) bytes_taken <= bytes_taken + 32'd8;
        else if (bytes_taken == '0) bytes_taken <= 32'd8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) chunk_pending <= 1'b0;
    else chunk_pending <= (cmd.op == OP_START || cmd.op == OP_ABSORB);
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_EXP_INIT: begin
        key0 <= (t0 == '0) ? 32'd1 : t0;
        key1 <= (t1 == '0) ? 32'd2 : t1;
        key2 <= PiW2;
      end
      OP_KEY_MIX: {key2, key1, key0} <= kmix;
      OP_SCR_PRE_A, OP_SCR_PRE_B, OP_SCR_POST_A, OP_SCR_POST_B: begin
        key0 <= k0n;
        key1 <= k1n;
        key2 <= k2n;
      end
      default: ;
    endcase
    if (cmd.op == OP_START || cmd.op == OP_ABSORB) begin
      chunk      <= chunk_data;
      chunk_last <= last_chunk;
    end
    if (cmd.op == OP_START) len_prod <= LenMul * (message_length + 32'd1);
    if (chunk_pending && is_short && !chunk_last && bytes_taken == '0)
      short_buffer <= chunk;
    if (cmd.op == OP_FINAL) begin
      fin_short <= is_short && msg_len <= 32'd3;
      if (is_short) begin
        fin_a <= sa;
        fin_b <= sb;
        fin_c <= sc;
      end else begin
        fin_a <= la;
        fin_b <= lb;
        fin_c <= lc;
      end
    end
    if (cmd.op == OP_FIN1) begin
      if (fin_short) {fin_c, fin_a} <= short_fin1(fin_a, fin_c);
      else {fin_c, fin_b, fin_a} <= common_fin1(fin_a, fin_b, fin_c);
    end
    if (cmd.op == OP_FIN2) begin
      if (fin_short) {fin_c, fin_a} <= short_fin2(fin_a, fin_c);
      else {fin_c, fin_b, fin_a} <= common_fin2(fin_a, fin_b, fin_c);
    end
    if (cmd.load_out)
      hash_reg <= fin_short ? short_fin3(fin_a, fin_c) : common_fin3(fin_a, fin_b, fin_c);
  end

endmodule

// ===== hw/rtl/zaphod32_stream_hash_unit.sv =====
// Zaphod32 hash over a stream of 8-byte little-endian chunks. The length is
// sampled with the first chunk; one hash comes out after the last chunk. A
// chunk passes through the absorb step before the next is taken (a first chunk
// also runs the length multiply before it); a last chunk adds the tail fold,
// two finalize stages and the result register load, and the load waits while an
// earlier result is still held. Seed writes are taken only while idle; a write
// re-expands the key words in a sequencer, during which no chunk is taken; the
// same expansion runs after reset.
module zaphod32_stream_hash_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] hash_seed,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] chunk_data,
  input  logic        first_chunk,
  input  logic        last_chunk,
  input  logic [31:0] message_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_value
);
  import zaphod_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic        busy;
  logic        seed_we;
  logic [63:0] seed;

  assign cfg_ready = !busy;
  assign seed_we   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) seed <= '0;
    else if (seed_we) seed <= hash_seed;
  end

  zaphod_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .seed_we     (seed_we),
    .chunk_valid (in_valid),
    .chunk_ready (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy)
  );

  zaphod_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .seed           (seed),
    .chunk_data     (chunk_data),
    .first_chunk    (first_chunk),
    .last_chunk     (last_chunk),
    .message_length (message_length),
    .hash_value     (hash_value)
  );

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("chunk taken during busy");

  a_seed_restarts: assert property (@(posedge clk) disable iff (rst)
    seed_we |=> busy) else $error("seed write did not restart expansion");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hash_value))
    else $error("result dropped");

endmodule

// ===== verif/zaphod32_stream_hash_unit_tb.sv =====
`timescale 1ns / 100ps

module zaphod32_stream_hash_unit_tb;
  import zaphod_pkg::*;

  typedef struct {
    logic [63:0] data;
    logic        first;
    logic        last;
    logic [31:0] len;
  } chunk_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] hash_seed;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] chunk_data;
  logic        first_chunk;
  logic        last_chunk;
  logic [31:0] message_length;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] hash_value;

  zaphod32_stream_hash_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .hash_seed(hash_seed),
    .in_valid(in_valid), .in_ready(in_ready), .chunk_data(chunk_data),
    .first_chunk(first_chunk), .last_chunk(last_chunk),
    .message_length(message_length),
    .out_valid(out_valid), .out_ready(out_ready), .hash_value(hash_value)
  );

  // predictor state
  logic [31:0] key_w [3];
  logic [31:0] run_w [3];
  logic [31:0] taken;
  logic [31:0] cur_len;
  logic [63:0] held_chunk;

  chunk_t      pending_chunks[$];
  logic [31:0] expected_hashes[$];
  int          error_count;
  bit          calm;
  int          send_gap;
  int          recv_gap;
  logic [63:0] seed_pending;
  bit          seed_req;

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [31:0] rl(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] scram(input logic [31:0] v_in, input logic [31:0] p);
    logic [31:0] v;
    v = v_in;
    v ^= v >> 9;
    v ^= v << 21;
    v ^= v >> 16;
    v = v * p;
    v ^= v >> 17;
    v ^= v << 15;
    v ^= v >> 23;
    return v;
  endfunction

  task automatic round3(inout logic [31:0] a, inout logic [31:0] b, inout logic [31:0] c);
    a = rl(a, 16) - c;
    b = rl(b, 19) ^ c;
    c = rl(c, 17) + b;
    a = rl(a, 30) + b;
    b = rl(b, 15) - a;
    c = rl(c, 25) ^ a;
  endtask

  task automatic derive_keys(input logic [63:0] s);
    logic [31:0] a, b, c;
    a = s[31:0] ^ 32'h43f6a888;
    b = s[63:32] ^ 32'h5a308d31;
    c = 32'h3198a2e0;
    if (a == 0) a = 1;
    if (b == 0) b = 2;
    if (c == 0) c = 4;
    a = scram(a, 32'h9fade23b);
    b = scram(b, 32'haa6f908d);
    c = scram(c, 32'hcdf6b72d);
    repeat (4) round3(a, b, c);
    a = scram(a, 32'hc95d22a9);
    b = scram(b, 32'h8497242b);
    c = scram(c, 32'h9c5cc4e9);
    repeat (5) round3(a, b, c);
    key_w[0] = a;
    key_w[1] = b;
    key_w[2] = c;
  endtask

  function automatic logic [31:0] tiny_finish(input logic [31:0] a_in, input logic [31:0] c_in);
    logic [31:0] a, c;
    a = a_in;
    c = c_in;
    a = a - c;
    c = rl(c, 8) ^ a;
    a = rl(a, 16) + c;
    c = c + a;
    a = a + (a >> 9);
    a = a + c;
    c ^= a;
    c = c + (c << 4);
    a = a - c;
    c = rl(c, 24) ^ a;
    a = rl(a, 16) ^ c;
    c = rl(c, 10) + a;
    a = rl(a, 2) + c;
    c = rl(c, 20);
    return a ^ c;
  endfunction

  function automatic logic [31:0] full_finish(input logic [31:0] a_in, input logic [31:0] b_in,
                                              input logic [31:0] c_in);
    logic [31:0] a, b, c;
    a = a_in;
    b = b_in;
    c = c_in;
    c = c + a;
    b = b - c;
    b = rl(b, 6);
    c ^= b;
    c = rl(c, 28);
    b ^= c;
    a = a + b;
    b = rl(b, 24);
    c = c + b;
    c = rl(c, 18) + b;
    a ^= c;
    a = rl(a, 20);
    c = c + a;
    b ^= c;
    a = a + b;
    a = rl(a, 5);
    c = c + a;
    c = rl(c, 22);
    a = a - b;
    b = b - c;
    b = rl(b, 17);
    return a ^ b ^ c;
  endfunction

  function automatic logic [31:0] short_digest(input logic [63:0] lo, input logic [31:0] hi);
    logic [31:0] a, b, c, w0, w1;
    a = run_w[0];
    b = run_w[1];
    c = run_w[2];
    w0 = lo[31:0];
    w1 = lo[63:32];
    case (cur_len)
      12: return full_finish(a + w0, b - w1, c + (hi[31:24] << 24) + (hi[23:16] << 16)
                             + hi[15:0]);
      11: return full_finish(a + w0, b - w1, c + (hi[23:16] << 16) + hi[15:0]);
      10: return full_finish(a + w0, b - w1, c + hi[15:0]);
      9:  return full_finish(a + w0, b - w1, c + hi[7:0]);
      8:  return full_finish(a + w0, b - w1, c);
      7:  return full_finish(a + w1[15:0], b - w0, c + w1[23:16]);
      6:  return full_finish(a + w1[15:0], b - w0, c);
      5:  return full_finish(a + w1[7:0], b - w0, c);
      4:  return full_finish(a, b - w0, c);
      3:  return tiny_finish(a + w0[15:0], c + w0[23:16]);
      2:  return tiny_finish(a + w0[15:0], c);
      1:  return tiny_finish(a + w0[7:0], c);
      default: return tiny_finish(a, c ^ 32'hFF);
    endcase
  endfunction

  task automatic absorb(input logic [63:0] d);
    run_w[1] = run_w[1] - d[31:0];
    run_w[0] = run_w[0] + d[63:32];
    round3(run_w[0], run_w[1], run_w[2]);
  endtask

  // returns 1 and the hash when the chunk closes a message
  task automatic predict_chunk(input chunk_t ch, output bit has, output logic [31:0] h);
    logic [2:0]  t;
    logic [63:0] rest;
    has = 0;
    h = 0;
    if (ch.first) begin
      cur_len = ch.len;
      run_w[0] = key_w[0];
      run_w[1] = key_w[1];
      run_w[2] = key_w[2] ^ (32'hC41A7AB1 * (cur_len + 1));
      taken = 0;
    end
    if (cur_len <= 12) begin
      if (!ch.last) begin
        if (taken == 0) begin
          held_chunk = ch.data;
          taken = 8;
        end
        return;
      end
      has = 1;
      h = (taken == 0) ? short_digest(ch.data, 0) : short_digest(held_chunk, ch.data[31:0]);
      taken += 8;
      return;
    end
    taken += 8;
    if (!ch.last) begin
      absorb(ch.data);
      return;
    end
    t = cur_len[2:0];
    rest = ch.data;
    if (t == 0) absorb(ch.data);
    else if (t >= 4) begin
      run_w[1] = run_w[1] - ch.data[31:0];
      rest = ch.data >> 32;
    end
    run_w[0] = run_w[0] + (cur_len << 24);
    case (t[1:0])
      3: begin
        run_w[2] = run_w[2] + rest[23:16];
        run_w[0] = run_w[0] + rest[15:0];
      end
      2: run_w[0] = run_w[0] + rest[15:0];
      1: run_w[0] = run_w[0] + rest[7:0];
      default: run_w[2] = run_w[2] ^ 32'hFF;
    endcase
    has = 1;
    h = full_finish(run_w[0], run_w[1], run_w[2]);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    bit has;
    logic [31:0] h;
    chunk_t ch;
    if (rst) begin
      in_valid <= 0;
      cfg_valid <= 0;
      send_gap <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        derive_keys(hash_seed);
        cfg_valid <= 0;
      end else if (seed_req && !cfg_valid) begin
        hash_seed <= seed_pending;
        cfg_valid <= 1;
      end
      if (in_valid && in_ready) begin
        ch.data = chunk_data;
        ch.first = first_chunk;
        ch.last = last_chunk;
        ch.len = message_length;
        predict_chunk(ch, has, h);
        if (has) expected_hashes.push_back(h);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 0;
        end else if (pending_chunks.size() > 0) begin
          ch = pending_chunks.pop_front();
          chunk_data <= ch.data;
          first_chunk <= ch.first;
          last_chunk <= ch.last;
          message_length <= ch.len;
          in_valid <= 1;
          if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 9);
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      recv_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_hashes.size() == 0)
          report_mismatch($sformatf("unexpected hash %h", hash_value));
        else begin
          logic [31:0] e;
          e = expected_hashes.pop_front();
          if (hash_value !== e)
            report_mismatch($sformatf("hash_value %h, want %h", hash_value, e));
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        if (!calm && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 9);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_chunk(input logic [63:0] d, input bit f, input bit l, input logic [31:0] n);
    chunk_t ch;
    ch.data = d;
    ch.first = f;
    ch.last = l;
    ch.len = n;
    pending_chunks.push_back(ch);
  endtask

  // well-formed message of n bytes
  task automatic push_message(input logic [31:0] n);
    int cnt;
    cnt = (n == 0) ? 1 : (n + 7) / 8;
    for (int i = 0; i < cnt; i++)
      push_chunk(rand64(), i == 0, i == cnt - 1, (i == 0) ? n : $urandom);
  endtask

  task automatic drain();
    wait (pending_chunks.size() == 0 && !in_valid);
    wait (expected_hashes.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] s);
    @(posedge clk);
    seed_pending = s;
    seed_req = 1;
    wait (cfg_valid);
    seed_req = 0;
    wait (!cfg_valid);
    repeat (2) @(posedge clk);
  endtask

  task automatic random_phase(input int items);
    int sent;
    int r;
    logic [31:0] n;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(0, 19);
      if (r < 16) begin
        n = (r < 8) ? 32'($urandom_range(0, 12)) : 32'($urandom_range(13, 64));
        push_message(n);
        sent += (n == 0) ? 1 : int'((n + 7) / 8);
      end else if (r == 16) begin
        // first chunk with a random length, closed by the next chunk
        push_chunk(rand64(), 1, 0, $urandom);
        push_chunk(rand64(), 0, 1, $urandom);
        sent += 2;
      end else begin
        // broken sequences: stray chunks, mismatched counts
        push_chunk(rand64(), $urandom_range(0, 1), $urandom_range(0, 1), $urandom);
        sent += 1;
      end
    end
  endtask

  initial begin
    error_count = 0;
    calm = 0;
    seed_req = 0;
    hash_seed = 0;
    chunk_data = 0;
    first_chunk = 0;
    last_chunk = 0;
    message_length = 0;
    cfg_valid = 0;
    in_valid = 0;
    out_ready = 0;
    taken = 0;
    cur_len = 0;
    held_chunk = 0;
    run_w[0] = 0;
    run_w[1] = 0;
    run_w[2] = 0;
    derive_keys(64'h0);
    rst = 1;
    repeat (4) @(posedge clk);
    rst <= 0;
    // directed: stray chunk right after reset, then every short length
    push_chunk(64'hFFFF_FFFF_FFFF_FFFF, 0, 1, 0);
    for (int n = 0; n <= 13; n++) push_message(n);
    push_chunk(64'h0, 1, 1, 32'hFFFF_FFFF);
    push_chunk(64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 32'd12);
    push_chunk(rand64(), 0, 0, 0);
    push_chunk(rand64(), 0, 1, 0);
    push_chunk(rand64(), 0, 1, 0);
    push_message(16);
    push_message(23);
    drain();
    write_seed(64'hFFFF_FFFF_FFFF_FFFF);
    random_phase(300);
    drain();
    write_seed({32'h5a308d31, 32'h43f6a888});
    random_phase(300);
    drain();
    write_seed(64'h0);
    random_phase(300);
    drain();
    write_seed(rand64());
    random_phase(400);
    drain();
    calm = 1;
    random_phase(250);
    drain();
    if (error_count == 0)
      $display("zaphod32_stream_hash_unit_tb: clean");
    else
      $display("zaphod32_stream_hash_unit_tb: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("zaphod32_stream_hash_unit_tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/zaphod_pkg.sv
hw/rtl/zaphod_ctrl.sv
hw/rtl/zaphod_dp.sv
hw/rtl/zaphod32_stream_hash_unit.sv
verif/zaphod32_stream_hash_unit_tb.sv
